>>> rtl/tcpm_pkg.sv
// ============================================================================
// tcpm_pkg
// Shared types and constants for the tick-counted position mover: command
// and event codes, register indexes, reset values and the item structures.
// ============================================================================
package tcpm_pkg;

    // Width of the internal position and goal counters.
    localparam int POS_BITS = 16;

    // Field widths of the item ports.
    localparam int CMD_W   = 3;
    localparam int GOAL_W  = 16;
    localparam int SPEED_W = 7;
    localparam int DRIVE_W = 8;
    localparam int OPOS_W  = 16;
    localparam int EVENT_W = 3;
    localparam int TIME_W  = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Largest drive magnitude.
    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

    // Reset values of the configuration registers.
    localparam logic [SPEED_W-1:0] RST_FWD_SPEED  = 7'd0;
    localparam logic [SPEED_W-1:0] RST_REV_SPEED  = 7'd0;
    localparam logic [SPEED_W-1:0] RST_MIN_SPEED  = 7'd20;
    localparam logic [TIME_W-1:0]  RST_TIMEOUT_MS = 16'd500;

    // Saturation value of the watchdog counter.
    localparam logic [TIME_W-1:0] WDOG_MAX = '1;

    typedef logic [POS_BITS-1:0] t_pos;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FWD_SPEED  = 2'd0,
        REG_REV_SPEED  = 2'd1,
        REG_MIN_SPEED  = 2'd2,
        REG_TIMEOUT_MS = 2'd3
    } t_reg_idx;

    typedef enum logic [CMD_W-1:0] {
        CMD_START_SPEED   = 3'd0,
        CMD_START_DEFAULT = 3'd1,
        CMD_STOP          = 3'd2,
        CMD_HALL_TICK     = 3'd3,
        CMD_MS_TICK       = 3'd4,
        CMD_SET_HOME      = 3'd5
    } t_cmd;

    typedef enum logic [EVENT_W-1:0] {
        EVT_NONE        = 3'd0,
        EVT_REACHED     = 3'd1,
        EVT_TIMEOUT     = 3'd2,
        EVT_REED_STOP   = 3'd3,
        EVT_REED_REFUSE = 3'd4
    } t_event;

    // One input item.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [GOAL_W-1:0]  goal_position;
        logic [SPEED_W-1:0] move_speed;
        logic               reed_clear;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [DRIVE_W-1:0] motor_drive;
        logic               done_res;
        logic [OPOS_W-1:0]  position;
        logic [EVENT_W-1:0] event_res;
    } t_result;

endpackage

>>> rtl/tick_counted_position_mover_unit.sv
// ============================================================================
// tick_counted_position_mover_unit
// Bang-bang position mover driven by start, stop, hall tick, millisecond
// tick and set-home items, with a plain register write port.
// ============================================================================
//
//  Channel   Handshake             Carries
//  -------   -------------------   ------------------------------------------
//  input     i_valid / o_ready     cmd, goal_position, move_speed, reed_clear
//  output    o_valid / i_ready     motor_drive, done_res, position, event_res
//  config    i_cfg_we              i_cfg_idx, i_cfg_data (no wait)
//
//  An item is registered on acceptance and applied to the mover state once
//  the result register has room; its result is then registered there and
//  offered downstream. One item is accepted every cycle while results are
//  taken.
//  Synchronous active-low reset empties both registers and restores the
//  state and register defaults. A stalled result holds the core, and the
//  input register then fills and drops o_ready.
// ============================================================================
module tick_counted_position_mover_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tcpm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tcpm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [tcpm_pkg::CMD_W-1:0]        i_cmd,
    input  logic signed [tcpm_pkg::GOAL_W-1:0] i_goal_position,
    input  logic [tcpm_pkg::SPEED_W-1:0]      i_move_speed,
    input  logic                              i_reed_clear,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [tcpm_pkg::DRIVE_W-1:0] o_motor_drive,
    output logic                              o_done_res,
    output logic signed [tcpm_pkg::OPOS_W-1:0] o_position,
    output logic [tcpm_pkg::EVENT_W-1:0]      o_event_res
);

    tcpm_pkg::t_item   in_item;
    tcpm_pkg::t_item   core_item;
    tcpm_pkg::t_result core_result;
    tcpm_pkg::t_result out_result;
    logic              core_valid;
    logic              out_room;
    logic              fire;

    // Pack the input fields.
    assign in_item.cmd           = i_cmd;
    assign in_item.goal_position = i_goal_position;
    assign in_item.move_speed    = i_move_speed;
    assign in_item.reed_clear    = i_reed_clear;

    // The core consumes an item when the result register has room for it.
    assign fire = core_valid && out_room;

    tcpm_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (core_valid),
        .i_take  (out_room),
        .o_item  (core_item)
    );

    tcpm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (core_item),
        .o_result   (core_result)
    );

    tcpm_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .o_room   (out_room),
        .i_result (core_result),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    // Unpack the result fields.
    assign o_motor_drive = out_result.motor_drive;
    assign o_done_res    = out_result.done_res;
    assign o_position    = out_result.position;
    assign o_event_res   = out_result.event_res;

endmodule

>>> rtl/tcpm_in_stage.sv
// ============================================================================
// tcpm_in_stage
// Input register: captures one item and holds it until the core consumes it.
// ============================================================================
module tcpm_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tcpm_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_take,
    output tcpm_pkg::t_item o_item
);

    logic            r_valid;
    tcpm_pkg::t_item r_item;

    // The register can load whenever it is empty or its item leaves now.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Item payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/tcpm_core.sv
// ============================================================================
// tcpm_core
// Mover state and its single-pass update: one item is applied per cycle in
// which i_fire is raised and yields one result built from the updated state.
// ============================================================================
module tcpm_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tcpm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tcpm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_fire,
    input  tcpm_pkg::t_item                   i_item,
    output tcpm_pkg::t_result                 o_result
);

    // Configuration registers.
    logic [tcpm_pkg::SPEED_W-1:0] r_fwd_speed;
    logic [tcpm_pkg::SPEED_W-1:0] r_rev_speed;
    logic [tcpm_pkg::SPEED_W-1:0] r_min_speed;
    logic [tcpm_pkg::TIME_W-1:0]  r_timeout_ms;

    // Mover state and its next values.
    tcpm_pkg::t_pos               r_pos, n_pos;
    tcpm_pkg::t_pos               r_goal, n_goal;
    logic                         r_fwd, n_fwd;
    logic                         r_idle, n_idle;
    logic [tcpm_pkg::TIME_W-1:0]  r_since, n_since;
    logic [tcpm_pkg::DRIVE_W-1:0] r_drive, n_drive;

    tcpm_pkg::t_pos               goal_ext;
    logic                         start_fwd;
    logic [tcpm_pkg::SPEED_W-1:0] speed_sel;
    logic [tcpm_pkg::SPEED_W-1:0] speed_max;
    logic [tcpm_pkg::SPEED_W-1:0] mag;
    logic [tcpm_pkg::DRIVE_W-1:0] mag_pos;
    logic [tcpm_pkg::DRIVE_W-1:0] mag_neg;
    logic [tcpm_pkg::TIME_W-1:0]  since_aged;
    logic                         reached;
    tcpm_pkg::t_event             evt;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_speed  <= tcpm_pkg::RST_FWD_SPEED;
            r_rev_speed  <= tcpm_pkg::RST_REV_SPEED;
            r_min_speed  <= tcpm_pkg::RST_MIN_SPEED;
            r_timeout_ms <= tcpm_pkg::RST_TIMEOUT_MS;
        end else if (i_cfg_we) begin
            case (tcpm_pkg::t_reg_idx'(i_cfg_idx))
                tcpm_pkg::REG_FWD_SPEED:  r_fwd_speed  <= i_cfg_data[tcpm_pkg::SPEED_W-1:0];
                tcpm_pkg::REG_REV_SPEED:  r_rev_speed  <= i_cfg_data[tcpm_pkg::SPEED_W-1:0];
                tcpm_pkg::REG_MIN_SPEED:  r_min_speed  <= i_cfg_data[tcpm_pkg::SPEED_W-1:0];
                tcpm_pkg::REG_TIMEOUT_MS: r_timeout_ms <= i_cfg_data[tcpm_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Goal sign-extended (or truncated) to the counter width, and direction.
    assign goal_ext  = tcpm_pkg::POS_BITS'(signed'(i_item.goal_position));
    assign start_fwd = $signed(goal_ext) > $signed(r_pos);

    // Drive magnitude: larger of the speed and the minimum, capped at full scale.
    always_comb begin
        if (tcpm_pkg::t_cmd'(i_item.cmd) == tcpm_pkg::CMD_START_SPEED) begin
            speed_sel = i_item.move_speed;
        end else begin
            speed_sel = start_fwd ? r_fwd_speed : r_rev_speed;
        end
        speed_max = (speed_sel > r_min_speed) ? speed_sel : r_min_speed;
        mag       = (speed_max > tcpm_pkg::SPEED_MAX) ? tcpm_pkg::SPEED_MAX : speed_max;
        mag_pos   = {1'b0, mag};
        mag_neg   = tcpm_pkg::DRIVE_W'(0) - mag_pos;
    end

    // Watchdog aged by one millisecond, saturating.
    assign since_aged = (r_since == tcpm_pkg::WDOG_MAX) ? r_since
                                                         : r_since + 1'b1;

    // Target reached in the direction of travel.
    assign reached = r_fwd ? ($signed(r_pos) >= $signed(r_goal))
                           : ($signed(r_pos) <= $signed(r_goal));

    // Next state for the command in hand.
    always_comb begin
        n_pos   = r_pos;
        n_goal  = r_goal;
        n_fwd   = r_fwd;
        n_idle  = r_idle;
        n_since = r_since;
        n_drive = r_drive;
        evt     = tcpm_pkg::EVT_NONE;
        case (tcpm_pkg::t_cmd'(i_item.cmd))
            tcpm_pkg::CMD_START_SPEED: begin
                n_goal  = goal_ext;
                n_fwd   = start_fwd;
                n_idle  = 1'b0;
                n_since = '0;
                n_drive = start_fwd ? mag_pos : mag_neg;
            end
            tcpm_pkg::CMD_START_DEFAULT: begin
                n_goal  = goal_ext;
                n_fwd   = start_fwd;
                n_idle  = 1'b0;
                n_since = '0;
                if (!start_fwd) begin
                    n_drive = mag_neg;
                end else if (i_item.reed_clear) begin
                    n_drive = mag_pos;
                end else begin
                    // A forward start against a closed reed leaves the drive alone.
                    evt = tcpm_pkg::EVT_REED_REFUSE;
                end
            end
            tcpm_pkg::CMD_STOP: begin
                n_drive = '0;
                n_idle  = 1'b1;
            end
            tcpm_pkg::CMD_HALL_TICK: begin
                n_pos   = r_fwd ? r_pos + 1'b1 : r_pos - 1'b1;
                n_since = '0;
            end
            tcpm_pkg::CMD_MS_TICK: begin
                n_since = since_aged;
                if (!r_idle) begin
                    if (since_aged > r_timeout_ms) begin
                        n_drive = '0;
                        n_idle  = 1'b1;
                        evt     = tcpm_pkg::EVT_TIMEOUT;
                    end else if (reached) begin
                        n_drive = '0;
                        n_idle  = 1'b1;
                        evt     = tcpm_pkg::EVT_REACHED;
                    end else if (!i_item.reed_clear && r_fwd) begin
                        n_drive = '0;
                        n_idle  = 1'b1;
                        evt     = tcpm_pkg::EVT_REED_STOP;
                    end
                end
            end
            tcpm_pkg::CMD_SET_HOME: begin
                n_pos = '0;
            end
            default: ;
        endcase
    end

    // State registers, updated only when an item is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_goal  <= '0;
            r_fwd   <= 1'b1;
            r_idle  <= 1'b1;
            r_since <= '0;
            r_drive <= '0;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_goal  <= n_goal;
            r_fwd   <= n_fwd;
            r_idle  <= n_idle;
            r_since <= n_since;
            r_drive <= n_drive;
        end
    end

    // Result from the updated state.
    assign o_result.motor_drive = n_drive;
    assign o_result.done_res    = n_idle;
    assign o_result.position    = tcpm_pkg::OPOS_W'(n_pos);
    assign o_result.event_res   = evt;

endmodule

>>> rtl/tcpm_out_stage.sv
// ============================================================================
// tcpm_out_stage
// Result register: holds one result until the downstream side takes it.
// ============================================================================
module tcpm_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    output logic              o_room,
    input  tcpm_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output tcpm_pkg::t_result o_result
);

    logic              r_valid;
    tcpm_pkg::t_result r_result;

    // Room for a new result when empty or when the held one leaves now.
    assign o_room   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
